// ===== hw/rtl/spc_pkg.sv =====
// shared types, codes and default values for the stepper position controller
// no dependencies; used by every module of the block
package spc_pkg;

	localparam int QUEUE_DEPTH_DEF   = 8;
	localparam int POSITION_BITS_DEF = 16;
	localparam int VALUE_W           = 16;
	localparam int OPCODE_W          = 3;
	localparam int MODE_W            = 2;
	localparam int DELAY_W           = 17;

	localparam logic [VALUE_W-1:0] TICKS_PER_STEP_RESET = 16'd10;

	// input opcodes
	localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_GOTO  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_WAIT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_PACE  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CALIB = 3'd4;

	// reported mode codes
	localparam logic [MODE_W-1:0] MODE_CODE_HOMING = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CODE_IDLE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CODE_MOVING = 2'd2;

	typedef enum logic [1:0] {
		CLS_NOP  = 2'd0,
		CLS_TICK = 2'd1,
		CLS_CMD  = 2'd2
	} item_class_t;

	typedef enum logic [1:0] {
		KIND_GOTO  = 2'd0,
		KIND_WAIT  = 2'd1,
		KIND_PACE  = 2'd2,
		KIND_CALIB = 2'd3
	} cmd_kind_t;

	// controller mode, one-hot
	typedef enum logic [2:0] {
		MODE_HOMING = 3'b001,
		MODE_IDLE   = 3'b010,
		MODE_MOVING = 3'b100
	} mode_t;

	// classified item handed from front to back
	typedef struct packed {
		item_class_t          cls;
		cmd_kind_t            kind;
		logic [VALUE_W-1:0]   value;
		logic                 detector_active;
	} item_t;

	// one entry of the command queue
	typedef struct packed {
		cmd_kind_t          kind;
		logic [VALUE_W-1:0] arg;
	} queued_cmd_t;

	localparam int QCMD_W = $bits(queued_cmd_t);

endpackage

// ===== hw/rtl/spc_if.sv =====
// channel interfaces of the stepper position controller: items in, results out, config writes
// depends on spc_pkg for field widths
interface spc_item_if;
	import spc_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [VALUE_W-1:0]  value;
	logic                detector_active;

	modport source (output valid, output opcode, output value, output detector_active,
		input ready);
	modport sink (input valid, input opcode, input value, input detector_active,
		output ready);
endinterface

interface spc_result_if #(
	parameter int POSITION_BITS = spc_pkg::POSITION_BITS_DEF
);
	import spc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     step_left;
	logic                     step_right;
	logic [POSITION_BITS-1:0] position;
	logic [MODE_W-1:0]        mode;
	logic                     command_dropped;

	modport source (output valid, output step_left, output step_right, output position,
		output mode, output command_dropped, input ready);
	modport sink (input valid, input step_left, input step_right, input position,
		input mode, input command_dropped, output ready);
endinterface

interface spc_cfg_if;
	import spc_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spc_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on spc_pkg only for its default sizes; used for the command queue
module spc_ram #(
	parameter int WIDTH = spc_pkg::QCMD_W,
	parameter int DEPTH = spc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/spc_front.sv =====
// front stage: takes input transfers, classifies them and registers them for the item queue
// depends on spc_pkg and spc_if
module spc_front (
	input  logic          clk,
	input  logic          arst_n,
	spc_item_if.sink      item,
	output logic          push_valid,
	input  logic          push_ready,
	output spc_pkg::item_t push_item
);
	import spc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	assign item.ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_comb begin
		item_d.value           = item.value;
		item_d.detector_active = item.detector_active;
		item_d.cls             = CLS_NOP;
		item_d.kind            = KIND_GOTO;
		unique case (item.opcode) inside
			OP_TICK: begin
				item_d.cls = CLS_TICK;
			end
			OP_GOTO: begin
				item_d.cls  = CLS_CMD;
				item_d.kind = KIND_GOTO;
			end
			OP_WAIT: begin
				item_d.cls  = CLS_CMD;
				item_d.kind = KIND_WAIT;
			end
			OP_PACE: begin
				item_d.cls  = CLS_CMD;
				item_d.kind = KIND_PACE;
			end
			OP_CALIB: begin
				item_d.cls  = CLS_CMD;
				item_d.kind = KIND_CALIB;
			end
			default: begin
				item_d.cls = CLS_NOP; // undefined opcodes pass through as no-ops
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item_d;
		end
	end
endmodule

// ===== hw/rtl/spc_item_fifo.sv =====
// two-entry queue of classified items between the front and back stages
// depends on spc_pkg
module spc_item_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  spc_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output spc_pkg::item_t pop_item
);
	import spc_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

// ===== hw/rtl/spc_back.sv =====
// back stage: command queue, pace delay, homing/idle/moving state and result register
// depends on spc_pkg, spc_if and spc_ram
module spc_back #(
	parameter int QUEUE_DEPTH   = spc_pkg::QUEUE_DEPTH_DEF,
	parameter int POSITION_BITS = spc_pkg::POSITION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  spc_pkg::item_t              pop_item,
	input  logic [spc_pkg::VALUE_W-1:0] init_tps,
	spc_result_if.source                result
);
	import spc_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	// architectural state
	mode_t                    mode_q,   mode_d;
	logic [POSITION_BITS-1:0] pos_q,    pos_d;
	logic [POSITION_BITS-1:0] tgt_q,    tgt_d;
	logic [VALUE_W-1:0]       tps_q,    tps_d;
	logic [DELAY_W-1:0]       delay_q,  delay_d;
	logic [CNT_W-1:0]         count_q,  count_d;
	logic [IDX_W-1:0]         head_q,   head_d;
	logic [IDX_W-1:0]         tail_q,   tail_d;

	// queue ram and head bypass
	logic        q_we;
	queued_cmd_t q_wdata;
	logic [QCMD_W-1:0] q_rdata;
	queued_cmd_t byp_q;
	logic        use_byp_q;
	queued_cmd_t head_cmd;

	// result register
	logic                     res_valid_q;
	logic                     left_d, right_d, dropped_d;

	logic                     fire;
	logic [DELAY_W-1:0]       wait_d;
	logic [31:0]              arg_ext;
	logic [VALUE_W-1:0]       tps_new;
	logic [POSITION_BITS-1:0] tgt_new;
	mode_t                    mode_new;
	logic [MODE_W-1:0]        mode_code;

	assign fire      = pop_valid && (!res_valid_q || result.ready);
	assign pop_ready = !res_valid_q || result.ready;

	assign q_wdata.kind = pop_item.kind;
	assign q_wdata.arg  = pop_item.value;
	assign head_cmd     = use_byp_q ? byp_q : queued_cmd_t'(q_rdata);
	assign arg_ext      = 32'(head_cmd.arg);

	spc_ram #(
		.WIDTH (QCMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata (q_wdata),
		.raddr (head_d),
		.rdata (q_rdata)
	);

	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		tgt_d     = tgt_q;
		tps_d     = tps_q;
		delay_d   = delay_q;
		count_d   = count_q;
		head_d    = head_q;
		tail_d    = tail_q;
		q_we      = 1'b0;
		left_d    = 1'b0;
		right_d   = 1'b0;
		dropped_d = 1'b0;
		wait_d    = '0;
		tgt_new   = tgt_q;
		tps_new   = tps_q;
		mode_new  = mode_q;
		if (fire) begin
			case (pop_item.cls)
				CLS_TICK: begin
					if (delay_q > DELAY_W'(1)) begin
						delay_d = delay_q - DELAY_W'(1);
					end else begin
						delay_d = '0;
						unique case (mode_q)
							MODE_HOMING: begin
								pos_d = '0;
								tgt_d = '0;
								if (!pop_item.detector_active) begin
									left_d = 1'b1;
								end else begin
									mode_d = MODE_IDLE;
								end
								delay_d = DELAY_W'(tps_q);
							end
							MODE_IDLE: begin
								if (count_q != '0) begin
									head_d  = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
									count_d = count_q - CNT_W'(1);
									case (head_cmd.kind)
										KIND_GOTO:  tgt_new  = arg_ext[POSITION_BITS-1:0];
										KIND_WAIT:  wait_d   = DELAY_W'(head_cmd.arg);
										KIND_PACE:  tps_new  = head_cmd.arg;
										default:    mode_new = MODE_HOMING;
									endcase
									if (pos_q != tgt_new) begin
										mode_new = MODE_MOVING;
									end
									tgt_d   = tgt_new;
									tps_d   = tps_new;
									mode_d  = mode_new;
									delay_d = wait_d + DELAY_W'(tps_new);
								end
							end
							MODE_MOVING: begin
								if (pos_q < tgt_q) begin
									pos_d   = pos_q + POSITION_BITS'(1);
									right_d = 1'b1;
									delay_d = DELAY_W'(tps_q);
								end else if (pos_q > tgt_q) begin
									pos_d   = pos_q - POSITION_BITS'(1);
									left_d  = 1'b1;
									delay_d = DELAY_W'(tps_q);
								end else begin
									tps_d   = init_tps;
									mode_d  = MODE_IDLE;
									delay_d = DELAY_W'(init_tps);
								end
							end
							default: begin
								mode_d = MODE_HOMING;
							end
						endcase
					end
				end
				CLS_CMD: begin
					if (count_q == FULL_CNT) begin
						dropped_d = 1'b1;
					end else begin
						q_we    = 1'b1;
						tail_d  = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
						count_d = count_q + CNT_W'(1);
					end
				end
				default: begin
					// ignored item, result reports state only
				end
			endcase
		end
	end

	always_comb begin
		unique case (mode_d)
			MODE_HOMING: mode_code = MODE_CODE_HOMING;
			MODE_IDLE:   mode_code = MODE_CODE_IDLE;
			MODE_MOVING: mode_code = MODE_CODE_MOVING;
			default:     mode_code = MODE_CODE_HOMING;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_HOMING;
			pos_q       <= '0;
			tgt_q       <= '0;
			tps_q       <= TICKS_PER_STEP_RESET;
			delay_q     <= '0;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			use_byp_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			pos_q     <= pos_d;
			tgt_q     <= tgt_d;
			tps_q     <= tps_d;
			delay_q   <= delay_d;
			count_q   <= count_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			use_byp_q <= q_we && (tail_q == head_d);
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_q <= q_wdata;
		if (fire) begin
			result.step_left       <= left_d;
			result.step_right      <= right_d;
			result.position        <= pos_d;
			result.mode            <= mode_code;
			result.command_dropped <= dropped_d;
		end
	end

	assign result.valid = res_valid_q;
endmodule

// ===== hw/rtl/stepper_position_controller.sv =====
// top level of the stepper position controller
// depends on spc_pkg, spc_if, spc_front, spc_item_fifo, spc_back and spc_ram
//
// stepper position controller with homing. every input transfer is a tick or a command
// (goto, wait, set pace, calibrate) and yields exactly one result transfer, in order.
// commands go into a command queue of QUEUE_DEPTH entries; a command that meets a full
// queue is lost and its result has command_dropped set. ticks drive the motion state
// machine: homing steps left until the detector reads active and holds position at zero,
// idle takes one queued command per iteration, moving steps one position towards the
// target per iteration and restores initial_ticks_per_step when it arrives. one iteration
// runs every ticks_per_step ticks (a wait command adds its value once).
// rate: one item per clock cycle sustained while the result receiver is ready; an input
// transfer is registered in the front stage, the item queue and the result register. the
// back stage updates all state for an item at once, which sets that rate. the command
// queue ram prefetches the head entry, so a pop finds it ready. a two-entry queue sits
// between the classifying front and back stages and takes items while a result waits.
// initial_ticks_per_step is written through the cfg channel, always ready, and should
// only change while the block is idle.
module stepper_position_controller #(
	parameter int QUEUE_DEPTH   = spc_pkg::QUEUE_DEPTH_DEF,
	parameter int POSITION_BITS = spc_pkg::POSITION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	spc_item_if.sink     item,
	spc_result_if.source result,
	spc_cfg_if.sink      cfg
);
	import spc_pkg::*;

	// front to queue
	logic  push_valid;
	logic  push_ready;
	item_t push_item;

	// queue to back
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	// default pace register
	logic [VALUE_W-1:0] init_tps_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_tps_q <= TICKS_PER_STEP_RESET;
		end else if (cfg.valid) begin
			init_tps_q <= cfg.data;
		end
	end

	// classify and register each input transfer
	spc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decoupling queue between front and back
	spc_item_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// execute items and hold the result
	spc_back #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.init_tps  (init_tps_q),
		.result    (result)
	);
endmodule

// ===== tb/tb_stepper_position_controller.sv =====
// self-checking testbench for stepper_position_controller: directed and random items,
// each transfer predicted in the bench and compared field by field at the result port
// depends on spc_pkg, the channel interfaces in spc_if and the rtl of the block
module tb_stepper_position_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import spc_pkg::*;

	// opcodes the block must ignore
	localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = 3'd7;

	// the long receiver hold-off starts after this many results
	localparam int HOLD_AFTER_RESULTS = 700;
	localparam int HOLD_CYCLES        = 400;
	localparam int MAX_PRINTED        = 40;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [VALUE_W-1:0]  value;
		logic                det;
	} stim_item_t;

	typedef struct packed {
		logic                         step_left;
		logic                         step_right;
		logic [POSITION_BITS_DEF-1:0] position;
		logic [MODE_W-1:0]            mode;
		logic                         command_dropped;
	} motion_result_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [VALUE_W-1:0]  arg;
	} queued_op_t;

	logic clk;
	logic arst_n;

	spc_item_if   item_ch();
	spc_result_if result_ch();
	spc_cfg_if    cfg_ch();

	stepper_position_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// ---------------------------------------------------------------------------------
	// controller shadow state, advanced once per accepted item transfer
	// ---------------------------------------------------------------------------------
	logic [MODE_W-1:0]            ctl_mode;
	logic [POSITION_BITS_DEF-1:0] cur_pos;
	logic [POSITION_BITS_DEF-1:0] tgt_pos;
	logic [VALUE_W-1:0]           pace;
	logic [VALUE_W-1:0]           pace_default;
	logic [DELAY_W-1:0]           delay_left;
	queued_op_t                   cmd_backlog[$];

	stim_item_t     pending_items[$];
	motion_result_t expected_results[$];

	int errors;
	int items_in;
	int results_out;
	int drops_seen;
	int left_steps;
	int right_steps;
	int cfg_writes;

	// work out the result of one item and move the shadow state on
	function automatic motion_result_t advance_controller(input logic [OPCODE_W-1:0] op,
		input logic [VALUE_W-1:0] val, input logic det);
		motion_result_t r;
		logic [DELAY_W-1:0] extra;
		queued_op_t c;
		r = '0;
		extra = '0;
		if (op == OP_TICK) begin
			if (delay_left > DELAY_W'(1)) begin
				delay_left = delay_left - DELAY_W'(1);
			end else begin
				delay_left = '0;
				case (ctl_mode)
					MODE_CODE_HOMING: begin
						// position is pinned at zero until the detector trips
						cur_pos = '0;
						tgt_pos = '0;
						if (!det)
							r.step_left = 1'b1;
						else
							ctl_mode = MODE_CODE_IDLE;
						delay_left = DELAY_W'(pace);
					end
					MODE_CODE_IDLE: begin
						// an empty backlog loads no delay, so the next tick retries
						if (cmd_backlog.size() > 0) begin
							c = cmd_backlog.pop_front();
							case (c.op)
								OP_GOTO:  tgt_pos = c.arg[POSITION_BITS_DEF-1:0];
								OP_WAIT:  extra = DELAY_W'(c.arg);
								OP_PACE:  pace = c.arg;
								OP_CALIB: ctl_mode = MODE_CODE_HOMING;
								default:  ;
							endcase
							// a calibrate away from the target still turns into a move
							if (cur_pos != tgt_pos)
								ctl_mode = MODE_CODE_MOVING;
							delay_left = extra + DELAY_W'(pace);
						end
					end
					default: begin
						if (cur_pos < tgt_pos) begin
							cur_pos = cur_pos + POSITION_BITS_DEF'(1);
							r.step_right = 1'b1;
						end else if (cur_pos > tgt_pos) begin
							cur_pos = cur_pos - POSITION_BITS_DEF'(1);
							r.step_left = 1'b1;
						end else begin
							pace = pace_default;
							ctl_mode = MODE_CODE_IDLE;
						end
						delay_left = DELAY_W'(pace);
					end
				endcase
			end
		end else if (op <= OP_CALIB) begin
			if (cmd_backlog.size() >= QUEUE_DEPTH_DEF)
				r.command_dropped = 1'b1;
			else
				cmd_backlog.push_back('{op: op, arg: val});
		end
		r.position = cur_pos;
		r.mode = ctl_mode;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned seen,
		input int unsigned wanted);
		if (errors < MAX_PRINTED)
			$display("[%0t] result %0d: %s got %0d expected %0d", $time, results_out, what,
				seen, wanted);
		errors++;
	endtask

	// ---------------------------------------------------------------------------------
	// clock, and the limit on the whole run
	// ---------------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("stepper_position_controller verification failed");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// item driver: bursts of random length with random gaps, valid held until transfer
	// ---------------------------------------------------------------------------------
	int         burst_left;
	int         gap_left;
	stim_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.opcode <= OP_TICK;
			item_ch.value <= '0;
			item_ch.detector_active <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.opcode <= next_item.op;
				item_ch.value <= next_item.value;
				item_ch.detector_active <= next_item.det;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// now and then a long burst with no gap at all
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// result receiver: stall styles that change at random, plus one long hold-off so that
	// the block backs up and stalls its input
	// ---------------------------------------------------------------------------------
	int         taken;
	int         hold_left;
	bit         hold_done;
	int         style_left;
	int         stall_style;
	logic [7:0] stall_mask;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			taken = 0;
			hold_left = 0;
			hold_done = 1'b0;
			style_left = 0;
			stall_style = 0;
			stall_mask = 8'b1011_0010;
		end else begin
			if (result_ch.valid && result_ch.ready)
				taken++;
			stall_mask = {stall_mask[6:0], stall_mask[7]};
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!hold_done && taken >= HOLD_AFTER_RESULTS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style_left = $urandom_range(20, 80);
					stall_style = $urandom_range(0, 3);
				end else begin
					style_left--;
				end
				case (stall_style)
					0:       result_ch.ready <= 1'b1;
					1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
					2:       result_ch.ready <= ($urandom_range(0, 4) < 2);
					default: result_ch.ready <= stall_mask[0];
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// monitor: predicts at the item transfer, checks at the result transfer; both in
	// one process so the order within an edge is fixed
	// ---------------------------------------------------------------------------------
	motion_result_t predicted;
	motion_result_t want;
	motion_result_t got;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				pace_default = cfg_ch.data;
			if (item_ch.valid && item_ch.ready) begin
				predicted = advance_controller(item_ch.opcode, item_ch.value,
					item_ch.detector_active);
				expected_results.push_back(predicted);
				items_in++;
			end
			if (result_ch.valid && result_ch.ready) begin
				results_out++;
				got = '{step_left: result_ch.step_left, step_right: result_ch.step_right,
					position: result_ch.position, mode: result_ch.mode,
					command_dropped: result_ch.command_dropped};
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing outstanding, position", got.position, 0);
				end else begin
					want = expected_results.pop_front();
					if (got.step_left !== want.step_left)
						report_mismatch("step_left", got.step_left, want.step_left);
					if (got.step_right !== want.step_right)
						report_mismatch("step_right", got.step_right, want.step_right);
					if (got.position !== want.position)
						report_mismatch("position", got.position, want.position);
					if (got.mode !== want.mode)
						report_mismatch("mode", got.mode, want.mode);
					if (got.command_dropped !== want.command_dropped)
						report_mismatch("command_dropped", got.command_dropped,
							want.command_dropped);
					drops_seen += int'(want.command_dropped);
					left_steps += int'(want.step_left);
					right_steps += int'(want.step_right);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------------------
	task automatic add_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
		input logic det);
		pending_items.push_back('{op: op, value: val, det: det});
	endtask

	// commands mostly keep moves short so that many complete per phase
	function automatic stim_item_t random_command();
		stim_item_t s;
		int pick;
		pick = $urandom_range(0, 19);
		s.det = 1'($urandom_range(0, 1));
		if (pick < 10) begin
			s.op = OP_GOTO;
			s.value = ($urandom_range(0, 49) == 0) ? VALUE_W'($urandom_range(0, 300))
				: VALUE_W'($urandom_range(0, 48));
		end else if (pick < 14) begin
			s.op = OP_WAIT;
			s.value = ($urandom_range(0, 9) == 0) ? VALUE_W'($urandom_range(0, 60))
				: VALUE_W'($urandom_range(0, 6));
		end else if (pick < 18) begin
			s.op = OP_PACE;
			s.value = ($urandom_range(0, 9) == 0) ? VALUE_W'($urandom_range(0, 30))
				: VALUE_W'($urandom_range(0, 4));
		end else begin
			s.op = OP_CALIB;
			s.value = VALUE_W'($urandom);
		end
		return s;
	endfunction

	// mostly ticks with a trickle of commands, sometimes a run of commands that fills the
	// queue, and a little noise of undefined opcodes
	task automatic add_random_items(input int count);
		int n;
		int pick;
		stim_item_t s;
		n = 0;
		@(negedge clk);
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 84) begin
				add_item(OP_TICK, VALUE_W'($urandom), $urandom_range(0, 3) == 0);
				n++;
			end else if (pick < 96) begin
				s = random_command();
				pending_items.push_back(s);
				n++;
			end else if (pick < 98) begin
				add_item(OPCODE_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)),
					VALUE_W'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(4, 11)) begin
					s = random_command();
					pending_items.push_back(s);
					n++;
				end
			end
		end
	endtask

	task automatic write_default_pace(input logic [VALUE_W-1:0] pace_value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= pace_value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
	endtask

	// wait until every item has gone in and every result has come back, then let the
	// pipeline settle
	task automatic drain_and_pause();
		while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_TICK;
		item_ch.value = '0;
		item_ch.detector_active = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		ctl_mode = MODE_CODE_HOMING;
		cur_pos = '0;
		tgt_pos = '0;
		pace = TICKS_PER_STEP_RESET;
		pace_default = TICKS_PER_STEP_RESET;
		delay_left = '0;
		errors = 0;
		items_in = 0;
		results_out = 0;
		drops_seen = 0;
		left_steps = 0;
		right_steps = 0;
		cfg_writes = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_default_pace(16'd1);

		// directed: a homing step, undefined opcodes, every command with extreme
		// values, a full queue dropping two commands, then homing finishes on the
		// detector once the reset pace has run out
		@(negedge clk);
		add_item(OP_TICK, 16'hFFFF, 1'b0);
		add_item(OP_UNDEF_LO, 16'hFFFF, 1'b1);
		add_item(OP_UNDEF_LO + 3'd1, 16'h0000, 1'b0);
		add_item(OP_UNDEF_HI, 16'hA5A5, 1'b1);
		add_item(OP_PACE, 16'd0, 1'b0);
		add_item(OP_GOTO, 16'd5, 1'b1);
		add_item(OP_WAIT, 16'd0, 1'b0);
		add_item(OP_GOTO, 16'd2, 1'b0);
		add_item(OP_GOTO, 16'd2, 1'b1);
		add_item(OP_CALIB, 16'hFFFF, 1'b0);
		add_item(OP_PACE, 16'd1, 1'b0);
		add_item(OP_GOTO, 16'd0, 1'b0);
		add_item(OP_GOTO, 16'hFFFF, 1'b1);
		add_item(OP_WAIT, 16'hFFFF, 1'b0);
		repeat (10)
			add_item(OP_TICK, VALUE_W'($urandom), 1'b1);
		drain_and_pause();

		// random phases, each under its own default pace
		write_default_pace(16'd0);
		add_random_items(400);
		drain_and_pause();
		write_default_pace(16'd3);
		add_random_items(400);
		drain_and_pause();
		write_default_pace(16'd2);
		add_random_items(400);
		drain_and_pause();
		write_default_pace(16'd1);
		add_random_items(400);
		drain_and_pause();

		// last phase: the largest default pace and the largest command values; it may
		// leave the controller in a very long move or delay, which is why it comes last
		write_default_pace(16'hFFFF);
		add_random_items(60);
		add_item(OP_PACE, 16'hFFFF, 1'b1);
		add_item(OP_WAIT, 16'hFFFF, 1'b0);
		add_item(OP_GOTO, 16'hFFFF, 1'b1);
		add_item(OP_CALIB, 16'h0000, 1'b0);
		add_item(OP_GOTO, 16'h0000, 1'b1);
		repeat (20)
			add_item(OP_TICK, 16'hFFFF, 1'($urandom_range(0, 1)));
		drain_and_pause();

		repeat (10) @(posedge clk);
		$display("covered %0d item transfers and %0d results under %0d default pace settings",
			items_in, results_out, cfg_writes);
		$display("commands lost to a full queue: %0d, steps left: %0d, steps right: %0d",
			drops_seen, left_steps, right_steps);
		if (errors == 0) begin
			$display("stepper_position_controller verification clean");
		end else begin
			$display("stepper_position_controller verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/spc_pkg.sv
hw/rtl/spc_if.sv
hw/rtl/spc_ram.sv
hw/rtl/spc_front.sv
hw/rtl/spc_item_fifo.sv
hw/rtl/spc_back.sv
hw/rtl/stepper_position_controller.sv
tb/tb_stepper_position_controller.sv
